>>> hw/rtl/gbs_pkg.sv
// ---------------------------------------------------------------------------
// gbs_pkg: shared types and constants
// Widths, register codes, phase and state encodings, and the command and
// status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package gbs_pkg;

    localparam int PIX_W          = 8;
    localparam int IDX_W          = 19;
    localparam int SUM_W          = 18;
    localparam int SQ_W           = 26;
    localparam int LEARN_W        = 11;
    localparam int MULT_W         = 4;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 16;
    localparam int DEF_MAX_PIXELS = 524288;
    localparam int DIV_CNT_W      = $clog2(SUM_W + 1);

    localparam logic [PIX_W-1:0]   FG_VALUE    = 8'd255;
    localparam logic [PIX_W-1:0]   BG_VALUE    = 8'd0;
    localparam logic [LEARN_W-1:0] LEARN_RESET = 11'd300;
    localparam logic [LEARN_W-1:0] LEARN_MAX   = 11'd1024;
    localparam logic [LEARN_W-1:0] LEARN_MIN   = 11'd1;
    localparam logic [MULT_W-1:0]  MULT_RESET  = 4'd3;
    localparam logic [SQ_W-1:0]    SQ_MAX      = {SQ_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEARN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MULT  = 8'd1;

    typedef enum logic [1:0] {
        PH_LEARN_FIRST,
        PH_LEARN,
        PH_FINAL,
        PH_DETECT
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic wr_learn;
        logic div_start;
        logic div_step;
        logic mul1;
        logic mul2;
        logic wr_final;
        logic det_load;
    } ctrl_cmd_t;

    typedef struct packed {
        phase_t phase;
        logic   in_range;
        logic   div_done;
        logic   out_busy;
    } ctrl_status_t;

endpackage

>>> hw/rtl/gbs_ram.sv
// ---------------------------------------------------------------------------
// gbs_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds
// until the next read.
// ---------------------------------------------------------------------------
module gbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/gbs_datapath.sv
// ---------------------------------------------------------------------------
// gbs_datapath: model stores, arithmetic and result register
// Holds configuration, frame count, the two per-pixel stores, a restoring
// divider for the mean, the deviation multipliers and the mask compare.
// ---------------------------------------------------------------------------
module gbs_datapath #(
    parameter int MAX_PIXELS = gbs_pkg::DEF_MAX_PIXELS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [gbs_pkg::PIX_W-1:0]       s_pixel_value,
    input  logic [gbs_pkg::IDX_W-1:0]       s_pixel_index,
    input  logic                            s_end_of_frame,
    input  logic                            cfg_valid,
    input  logic [gbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  gbs_pkg::ctrl_cmd_t              cmd,
    output gbs_pkg::ctrl_status_t           status,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gbs_pkg::PIX_W-1:0]       m_mask_value,
    output logic [gbs_pkg::IDX_W-1:0]       m_mask_index
);
    import gbs_pkg::*;

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int PROD_W = 2 * SUM_W;
    localparam int P3_W   = PROD_W + LEARN_W;
    localparam int QF_W   = P3_W + 2;

    logic [LEARN_W-1:0] learn_reg;
    logic [MULT_W-1:0]  mult_reg;
    logic [LEARN_W-1:0] frame_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [IDX_W-1:0]   idx_reg;
    phase_t             phase_reg;
    logic               inside_reg;
    logic [LEARN_W-1:0] eff_l_reg;

    logic [LEARN_W-1:0] eff_l;
    phase_t             phase_now;
    logic               inside_now;

    logic [SUM_W-1:0]   sum_rd;
    logic [SQ_W-1:0]    sq_rd;
    logic [SUM_W-1:0]   sum_wdata;
    logic [SQ_W-1:0]    sq_wdata;
    logic               wr_en;
    logic [2*PIX_W-1:0] pix_sq;

    logic [LEARN_W-1:0]   rem_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [LEARN_W:0]     shifted;
    logic [LEARN_W:0]     trial;
    logic                 qbit;

    logic [PROD_W-1:0] p1_reg;
    logic [PROD_W-1:0] p2_reg;
    logic [P3_W-1:0]   p3_reg;
    logic [QF_W-1:0]   pos_sum;
    logic [QF_W-1:0]   neg_sum;
    logic [QF_W-1:0]   q_diff;
    logic [SQ_W-1:0]   q_clamped;

    logic [SUM_W-1:0]          pix_ext;
    logic [SUM_W-1:0]          diff;
    logic [SUM_W+LEARN_W-1:0]  lhs;
    logic [SQ_W+MULT_W-1:0]    rhs;
    logic                      fg;

    logic               m_valid_reg;
    logic [PIX_W-1:0]   mask_value_reg;
    logic [IDX_W-1:0]   mask_index_reg;

    // clamp the learn length to 1..LEARN_MAX; derive the frame phase and the index range check
    always_comb begin
        if (learn_reg < LEARN_MIN) begin
            eff_l = LEARN_MIN;
        end else if (learn_reg > LEARN_MAX) begin
            eff_l = LEARN_MAX;
        end else begin
            eff_l = learn_reg;
        end
        if (frame_reg < eff_l) begin
            phase_now = (frame_reg == '0) ? PH_LEARN_FIRST : PH_LEARN;
        end else if (frame_reg == eff_l) begin
            phase_now = PH_FINAL;
        end else begin
            phase_now = PH_DETECT;
        end
        inside_now = (32'(s_pixel_index) < 32'(MAX_PIXELS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learn_reg <= LEARN_RESET;
            mult_reg  <= MULT_RESET;
            frame_reg <= '0;
        end else begin
            if (cfg_valid && cfg_index == CFG_IDX_LEARN) begin
                learn_reg <= cfg_data[LEARN_W-1:0];
            end
            if (cfg_valid && cfg_index == CFG_IDX_MULT) begin
                mult_reg <= cfg_data[MULT_W-1:0];
            end
            // advance the frame count until detection starts
            if (cmd.capture && s_end_of_frame && frame_reg <= eff_l) begin
                frame_reg <= frame_reg + LEARN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pix_reg    <= s_pixel_value;
            idx_reg    <= s_pixel_index;
            phase_reg  <= phase_now;
            inside_reg <= inside_now;
            eff_l_reg  <= eff_l;
        end
    end

    // store update
    always_comb begin
        pix_sq  = (2*PIX_W)'(pix_reg) * (2*PIX_W)'(pix_reg);
        wr_en   = (cmd.wr_learn || cmd.wr_final) && inside_reg;
        if (cmd.wr_final) begin
            sum_wdata = quo_reg;
            sq_wdata  = q_clamped;
        end else if (phase_reg == PH_LEARN_FIRST) begin
            sum_wdata = SUM_W'(pix_reg);
            sq_wdata  = SQ_W'(pix_sq);
        end else begin
            sum_wdata = sum_rd + SUM_W'(pix_reg);
            sq_wdata  = sq_rd + SQ_W'(pix_sq);
        end
    end

    gbs_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_PIXELS),
        .ADDR_W(ADDR_W)
    ) u_sum_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(ADDR_W'(idx_reg)),
        .wr_data(sum_wdata),
        .rd_en  (cmd.rd_en),
        .rd_addr(ADDR_W'(idx_reg)),
        .rd_data(sum_rd)
    );

    gbs_ram #(
        .WIDTH (SQ_W),
        .DEPTH (MAX_PIXELS),
        .ADDR_W(ADDR_W)
    ) u_sq_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(ADDR_W'(idx_reg)),
        .wr_data(sq_wdata),
        .rd_en  (cmd.rd_en),
        .rd_addr(ADDR_W'(idx_reg)),
        .rd_data(sq_rd)
    );

    // restoring divider: one quotient bit per cycle
    always_comb begin
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        trial   = shifted - {1'b0, eff_l_reg};
        qbit    = (shifted >= {1'b0, eff_l_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_start) begin
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg <= '0;
            quo_reg <= sum_rd;
        end else if (cmd.div_step) begin
            rem_reg <= qbit ? trial[LEARN_W-1:0] : shifted[LEARN_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], qbit};
        end
        if (cmd.mul1) begin
            p1_reg <= PROD_W'(quo_reg) * PROD_W'(sum_rd);
            p2_reg <= PROD_W'(quo_reg) * PROD_W'(quo_reg);
        end
        if (cmd.mul2) begin
            p3_reg <= P3_W'(p2_reg) * P3_W'(eff_l_reg);
        end
    end

    // Q = s2 + L*m*m - 2*m*s, clamped to the store range
    always_comb begin
        pos_sum = QF_W'(sq_rd) + QF_W'(p3_reg);
        neg_sum = {QF_W'(p1_reg)} << 1;
        q_diff  = pos_sum - neg_sum;
        if (pos_sum < neg_sum) begin
            q_clamped = '0;
        end else if (q_diff > QF_W'(SQ_MAX)) begin
            q_clamped = SQ_MAX;
        end else begin
            q_clamped = q_diff[SQ_W-1:0];
        end
    end

    // foreground test: |pix - M| * L > mult * Q
    always_comb begin
        pix_ext = SUM_W'(pix_reg);
        diff    = (pix_ext >= sum_rd) ? (pix_ext - sum_rd) : (sum_rd - pix_ext);
        lhs     = (SUM_W+LEARN_W)'(diff) * (SUM_W+LEARN_W)'(eff_l_reg);
        rhs     = (SQ_W+MULT_W)'(mult_reg) * (SQ_W+MULT_W)'(sq_rd);
        fg      = inside_reg && ((SQ_W+MULT_W+1)'(lhs) > (SQ_W+MULT_W+1)'(rhs));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.det_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.det_load) begin
            mask_value_reg <= fg ? FG_VALUE : BG_VALUE;
            mask_index_reg <= idx_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mask_value = mask_value_reg;
    assign m_mask_index = mask_index_reg;

    assign status.phase    = phase_reg;
    assign status.in_range = inside_reg;
    assign status.div_done = (cnt_reg == DIV_CNT_W'(SUM_W));
    assign status.out_busy = m_valid_reg && !m_ready;

endmodule

>>> hw/rtl/gbs_ctrl.sv
// ---------------------------------------------------------------------------
// gbs_ctrl: sequencing state machine
// Steps each pixel through store read, then update, finalize or detect.
// ---------------------------------------------------------------------------
module gbs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gbs_pkg::ctrl_status_t status,
    output gbs_pkg::ctrl_cmd_t    cmd
);
    import gbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                case (status.phase)
                    PH_LEARN_FIRST, PH_LEARN: begin
                        cmd.wr_learn = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    PH_FINAL: begin
                        if (status.in_range) begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    PH_DETECT: begin
                        // hold until the result register is free
                        if (!status.out_busy) begin
                            cmd.det_load = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_MUL1;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.wr_final = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/gaussian_background_subtractor.sv
// ---------------------------------------------------------------------------
// gaussian_background_subtractor: single-Gaussian background model
// Learns a per-pixel mean and deviation sum, then marks foreground pixels.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one pixel per transaction (grey level, raster index, end of
//   frame mark). m_* carries one mask transaction per pixel once the model
//   is built: 255 for foreground, 0 for background, with the pixel index.
//   cfg_* writes learn_frames (index 0) and threshold_multiplier (index 1);
//   it is always ready and is meant to be used while the block is idle.
// Timing:
//   One pixel at a time. Learning and detecting pixels go through accept,
//   store read, then update or compare; a detect result shows on m_* the
//   cycle after the compare. A pixel of the finalizing frame goes through
//   accept, store read, divider start, 18 divide steps, a closing divider
//   state, two multiply stages and the store write.
// Reset and stall:
//   Reset clears the frame count, config registers and result valid; the
//   pixel stores are not cleared and are filled by the first learning frame.
//   A result held by a stalled receiver does not stop the next pixel from
//   being accepted; only the next result waits for the register to free.
module gaussian_background_subtractor #(
    parameter int MAX_PIXELS = gbs_pkg::DEF_MAX_PIXELS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gbs_pkg::PIX_W-1:0]       s_pixel_value,
    input  logic [gbs_pkg::IDX_W-1:0]       s_pixel_index,
    input  logic                            s_end_of_frame,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gbs_pkg::PIX_W-1:0]       m_mask_value,
    output logic [gbs_pkg::IDX_W-1:0]       m_mask_index,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gbs_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg_ready = 1'b1;

    gbs_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .status (status),
        .cmd    (cmd)
    );

    gbs_datapath #(
        .MAX_PIXELS(MAX_PIXELS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_pixel_value (s_pixel_value),
        .s_pixel_index (s_pixel_index),
        .s_end_of_frame(s_end_of_frame),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mask_value  (m_mask_value),
        .m_mask_index  (m_mask_index)
    );

endmodule

>>> hw/rtl/gbs_checker.sv
// ---------------------------------------------------------------------------
// gbs_checker: port-level checks for the background subtractor
// Watches the top level ports; attached by bind.
// ---------------------------------------------------------------------------
module gbs_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [gbs_pkg::PIX_W-1:0]  m_mask_value,
    input logic [gbs_pkg::IDX_W-1:0]  m_mask_index
);
    import gbs_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mask_value)
            && $stable(m_mask_index))
        else $error("result changed while stalled");

    a_mask_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_mask_value == FG_VALUE || m_mask_value == BG_VALUE))
        else $error("mask value is neither foreground nor background");

    // one pixel at a time: ready drops after each transaction
    a_seq_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous pixel in flight");

    // a new result rises only after input ready has been low, with a pixel in flight
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready, 1) && !$past(s_ready, 2))
        else $error("result without a pixel in flight");

endmodule

bind gaussian_background_subtractor gbs_checker u_gbs_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_mask_value(m_mask_value),
    .m_mask_index(m_mask_index)
);

>>> dv/gaussian_background_subtractor_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gaussian_background_subtractor_tb: self-checking bench for the subtractor
// Streams small frames over a fixed set of pixel positions through several
// learn lengths and multipliers. A background model in the scoreboard
// predicts every mask transaction, which is checked in order.
// ---------------------------------------------------------------------------
import gbs_pkg::*;

typedef struct {
    logic [PIX_W-1:0] value;
    logic [IDX_W-1:0] index;
} mask_t;

class mask_scoreboard;
    logic [SUM_W-1:0]   mean_sum [int];
    logic [SQ_W-1:0]    dev_sq [int];
    logic [LEARN_W-1:0] frame_cnt;
    logic [LEARN_W-1:0] learn_reg;
    logic [MULT_W-1:0]  mult_reg;
    mask_t              pending [$];
    int                 errors;

    function new();
        frame_cnt = '0;
        learn_reg = LEARN_RESET;
        mult_reg  = MULT_RESET;
        errors    = 0;
    endfunction

    function int learn_len();
        if (learn_reg < LEARN_MIN) return LEARN_MIN;
        if (learn_reg > LEARN_MAX) return LEARN_MAX;
        return learn_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_IDX_LEARN) learn_reg = data[LEARN_W-1:0];
        else if (idx == CFG_IDX_MULT) mult_reg = data[MULT_W-1:0];
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix, logic [IDX_W-1:0] idx, logic eof);
        int      n;
        longint  s, s2, m, q, diff;
        mask_t   r;
        n = learn_len();
        if (frame_cnt < n) begin
            if (frame_cnt == 0) begin
                mean_sum[idx] = SUM_W'(pix);
                dev_sq[idx]   = SQ_W'(pix) * SQ_W'(pix);
            end else begin
                mean_sum[idx] = mean_sum[idx] + SUM_W'(pix);
                dev_sq[idx]   = dev_sq[idx] + SQ_W'(pix) * SQ_W'(pix);
            end
        end else if (frame_cnt == n) begin
            s  = mean_sum[idx];
            s2 = dev_sq[idx];
            m  = s / n;
            q  = s2 - 2 * m * s + n * m * m;
            if (q < 0) q = 0;
            if (q > SQ_MAX) q = SQ_MAX;
            mean_sum[idx] = m[SUM_W-1:0];
            dev_sq[idx]   = q[SQ_W-1:0];
        end else begin
            m    = mean_sum[idx];
            diff = (pix >= m) ? pix - m : m - pix;
            r.value = (diff * n > mult_reg * longint'(dev_sq[idx])) ? FG_VALUE : BG_VALUE;
            r.index = idx;
            pending = {pending, r};
        end
        if (eof && frame_cnt <= n) frame_cnt = frame_cnt + LEARN_W'(1);
    endfunction

    function void check_mask(logic [PIX_W-1:0] val, logic [IDX_W-1:0] idx);
        mask_t e;
        if (pending.size() == 0) begin
            $error("unexpected mask transaction value=%0d index=%0d", val, idx);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (val !== e.value) begin
            $error("mask_value expected %0d actual %0d", e.value, val);
            errors++;
        end
        if (idx !== e.index) begin
            $error("mask_index expected %0d actual %0d", e.index, idx);
            errors++;
        end
    endfunction
endclass

module gaussian_background_subtractor_tb;

    localparam int NPOS      = 8;
    localparam int MAX_CYCLE = 400000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel_value;
    logic [IDX_W-1:0]      s_pixel_index;
    logic                  s_end_of_frame;
    logic                  m_valid;
    logic                  m_ready;
    logic [PIX_W-1:0]      m_mask_value;
    logic [IDX_W-1:0]      m_mask_index;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mask_scoreboard   sb;
    logic [IDX_W-1:0] positions [NPOS];
    int               burst_left;
    int               cycle_cnt;

    gaussian_background_subtractor DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // receiver: long stretches always ready, otherwise random stalls
    initial m_ready = 1'b0;
    always @(negedge aclk) begin
        if ((cycle_cnt % 600) < 200) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 9) < 6);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_mask(m_mask_value, m_mask_index);
    end

    initial cycle_cnt = 0;
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] pix, logic [IDX_W-1:0] idx, logic eof);
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid        = 1'b1;
        s_pixel_value  = pix;
        s_pixel_index  = idx;
        s_end_of_frame = eof;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(pix, idx, eof);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // hold off until every mask transaction is back and the block is quiet
    task automatic drain();
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    function automatic logic [PIX_W-1:0] pick_value(logic [IDX_W-1:0] idx);
        int m;
        if (sb.frame_cnt <= sb.learn_len() || $urandom_range(0, 3) == 0)
            return PIX_W'($urandom_range(0, 255));
        m = sb.mean_sum[idx] + $urandom_range(0, 40) - 20;
        if (m < 0) m = 0;
        if (m > 255) m = 255;
        return PIX_W'(m);
    endfunction

    task automatic send_frame(int npix);
        logic [IDX_W-1:0] idx;
        for (int k = 0; k < npix; k++) begin
            idx = positions[$urandom_range(0, NPOS - 1)];
            send_pixel(pick_value(idx), idx, k == npix - 1);
        end
    endtask

    task automatic run_episode(logic [CFG_DATA_W-1:0] learn, logic [CFG_DATA_W-1:0] mult,
                               int detect_frames, int learn_pix);
        drain();
        write_cfg(CFG_IDX_LEARN, learn);
        write_cfg(CFG_IDX_MULT, mult);
        while (sb.frame_cnt < sb.learn_len()) send_frame(learn_pix);
        // finalize every known position
        if (sb.frame_cnt == sb.learn_len())
            for (int k = 0; k < NPOS; k++)
                send_pixel(PIX_W'($urandom_range(0, 255)), positions[k], k == NPOS - 1);
        repeat (detect_frames) send_frame($urandom_range(1, 8));
    endtask

    initial begin
        sb             = new();
        burst_left     = 0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_pixel_value  = '0;
        s_pixel_index  = '0;
        s_end_of_frame = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        positions[0] = '0;
        positions[1] = '1;
        for (int k = 2; k < NPOS; k++) positions[k] = IDX_W'($urandom_range(0, 524287));
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // out-of-list register indexes must be ignored
        write_cfg(8'd2, 16'hFFFF);
        write_cfg(8'hFF, 16'h0001);
        // zero learn length clamps to one; first frame covers every position
        write_cfg(CFG_IDX_LEARN, 16'd0);
        write_cfg(CFG_IDX_MULT, 16'd0);
        send_pixel(8'd0, positions[0], 1'b0);
        send_pixel(8'd255, positions[1], 1'b0);
        for (int k = 2; k < NPOS; k++)
            send_pixel(PIX_W'($urandom_range(0, 255)), positions[k], k == NPOS - 1);
        run_episode(16'd0, 16'd0, 20, 4);
        // raise the learn length: learning resumes on top of the old model
        run_episode(16'd6, 16'd3, 20, 6);
        // oversized learn length clamps to the maximum
        run_episode(16'hFFFF, 16'd15, 10, 1);
        run_episode(16'd1024, 16'd15, 30, 1);
        run_episode(16'd1, 16'd7, 40, 1);
        run_episode(16'd300, 16'd1, 40, 1);

        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (sb.errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
